// ----- design/tcml_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcml_pkg
// Shared types, constants and helpers of the ternary classifier match list.
// ----------------------------------------------------------------------------
package tcml_pkg;

    localparam int MAX_ENTRIES   = 64;
    localparam int MAX_POSITIONS = 32;
    localparam int ENTRY_AW      = $clog2(MAX_ENTRIES);
    localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
    localparam int POS_CNT_W     = 6;
    localparam int SPEC_W        = 6;
    localparam int WORD_W        = 32;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    // Request command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    // Register indexes (selected by paddr[2])
    localparam logic REG_POS_COUNT = 1'b0;
    localparam logic REG_CLS_COUNT = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_MATCH = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef struct packed {
        logic                command;
        logic [5:0]          entry_index;
        logic [WORD_W-1:0]   care_bits;
        logic [WORD_W-1:0]   value_bits;
        logic [WORD_W-1:0]   message_bits;
    } t_in_item;

    typedef struct packed {
        t_kind               result_kind;
        logic [5:0]          match_index;
        logic [SPEC_W-1:0]   specificity;
        logic [CNT_W-1:0]    match_total;
        logic                last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FIN,
        ST_EMIT,
        ST_NONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic load_put;
        logic scan_step;
        logic emit_start;
        logic emit_skip;
        logic emit_put;
        logic none_put;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_match;
        logic scan_done;
        logic total_zero;
        logic cur_hit;
        logic emit_last;
        logic out_free;
    } t_dp_status;

    // Mask of the compared low positions; counts above the maximum saturate
    function automatic logic [WORD_W-1:0] pos_mask(input logic [POS_CNT_W-1:0] pc);
        logic [POS_CNT_W-1:0] pc_sat;
        logic [WORD_W:0]      m;
        pc_sat = (pc > POS_CNT_W'(MAX_POSITIONS)) ? POS_CNT_W'(MAX_POSITIONS) : pc;
        m      = ({{WORD_W{1'b0}}, 1'b1} << pc_sat) - {{WORD_W{1'b0}}, 1'b1};
        return m[WORD_W-1:0];
    endfunction

    // Saturate the entry count to the table depth
    function automatic logic [CNT_W-1:0] entry_count(input logic [CNT_W-1:0] cc);
        return (cc > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cc;
    endfunction

    // Count set bits of one word
    function automatic logic [SPEC_W-1:0] ones_count(input logic [WORD_W-1:0] x);
        logic [SPEC_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++) begin
            n = n + SPEC_W'(x[i]);
        end
        return n;
    endfunction

endpackage

// ----- design/tcml_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcml_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcml_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word a cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/tcml_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcml_dp
// Datapath: condition table, entry scan and compare, match flags, result
// counters and the output register.
// ----------------------------------------------------------------------------
module tcml_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcml_pkg::t_dp_cmd             i_cmd,
    output tcml_pkg::t_dp_status          o_status,
    input  tcml_pkg::t_in_item            i_in_data,
    input  logic [tcml_pkg::POS_CNT_W-1:0] i_pos_count,
    input  logic [tcml_pkg::CNT_W-1:0]    i_cls_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tcml_pkg::t_out_item           o_out_data
);
    import tcml_pkg::*;

    t_in_item                r_item;
    logic [WORD_W-1:0]       r_mask;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_cmp_vld;
    logic [ENTRY_AW-1:0]     r_cmp_idx;
    logic [MAX_ENTRIES-1:0]  r_flags;
    logic [CNT_W-1:0]        r_total;
    logic [CNT_W-1:0]        r_sent;
    logic                    r_out_vld;
    t_out_item               r_out;

    logic [2*WORD_W-1:0]     rd_word;
    logic [WORD_W-1:0]       rd_care;
    logic [WORD_W-1:0]       rd_value;
    logic                    entry_hit;
    logic                    out_free;
    logic                    scan_done;

    // Condition table: care mask in the upper half, value in the lower half
    tcml_ram #(
        .WIDTH (2 * WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_put),
        .i_waddr (r_item.entry_index[ENTRY_AW-1:0]),
        .i_wdata ({r_item.care_bits, r_item.value_bits}),
        .i_raddr (r_idx[ENTRY_AW-1:0]),
        .o_rdata (rd_word)
    );

    assign rd_care   = rd_word[2*WORD_W-1:WORD_W];
    assign rd_value  = rd_word[WORD_W-1:0];
    assign entry_hit = (((rd_value ^ r_item.message_bits) & rd_care & r_mask) == '0);
    assign out_free  = !r_out_vld || !i_out_stall;
    assign scan_done = (r_idx >= r_n);

    // Status towards the controller
    always_comb begin
        o_status.is_match   = (i_in_data.command == CMD_MATCH);
        o_status.scan_done  = scan_done;
        o_status.total_zero = (r_total == '0);
        o_status.cur_hit    = r_flags[r_idx[ENTRY_AW-1:0]];
        o_status.emit_last  = ((r_sent + CNT_W'(1)) == r_total);
        o_status.out_free   = out_free;
    end

    // Latch the request and its view of the configuration
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_in_data;
            r_mask <= pos_mask(i_pos_count);
            r_n    <= entry_count(i_cls_count);
        end
    end

    // Advance the scan and emit index, track compares in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
            r_sent    <= '0;
        end else begin
            if (i_cmd.take || i_cmd.emit_start) begin
                r_idx     <= '0;
                r_sent    <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= !scan_done;
                r_cmp_idx <= r_idx[ENTRY_AW-1:0];
                if (!scan_done) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end else if (i_cmd.emit_skip) begin
                r_idx <= r_idx + CNT_W'(1);
            end else if (i_cmd.emit_put) begin
                r_idx  <= r_idx + CNT_W'(1);
                r_sent <= r_sent + CNT_W'(1);
            end
        end
    end

    // Update the match flag of the compared entry and count the hits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.take) begin
                r_total <= '0;
            end else if (r_cmp_vld) begin
                r_flags[r_cmp_idx] <= entry_hit;
                if (entry_hit) begin
                    r_total <= r_total + CNT_W'(1);
                end
            end
        end
    end

    // Output register: load a new result or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_put || i_cmd.emit_put || i_cmd.none_put) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_put) begin
            r_out.result_kind <= KIND_LOAD;
            r_out.match_index <= r_item.entry_index;
            r_out.specificity <= ones_count(r_item.care_bits & r_mask);
            r_out.match_total <= '0;
            r_out.last        <= 1'b1;
        end else if (i_cmd.emit_put) begin
            r_out.result_kind <= KIND_MATCH;
            r_out.match_index <= r_idx[ENTRY_AW-1:0];
            r_out.specificity <= '0;
            r_out.match_total <= r_total;
            r_out.last        <= ((r_sent + CNT_W'(1)) == r_total);
        end else if (i_cmd.none_put) begin
            r_out.result_kind <= KIND_NONE;
            r_out.match_index <= '0;
            r_out.specificity <= '0;
            r_out.match_total <= '0;
            r_out.last        <= 1'b1;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- design/tcml_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcml_ctrl
// Controller: sequences load, scan, hit emission and the no-match result.
// ----------------------------------------------------------------------------
module tcml_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tcml_pkg::t_dp_status  i_status,
    output tcml_pkg::t_dp_cmd     o_cmd
);
    import tcml_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.is_match ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = i_status.total_zero ? ST_NONE : ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.cur_hit && i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_NONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            ST_LOAD: begin
                o_cmd.load_put = i_status.out_free;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_FIN: begin
                o_cmd.emit_start = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.emit_skip = !i_status.cur_hit;
                o_cmd.emit_put  = i_status.cur_hit && i_status.out_free;
            end
            ST_NONE: begin
                o_cmd.none_put = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/ternary_classifier_match_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_classifier_match_list
// Ternary condition table: loads entries, matches a message against the
// active entries and lists the matching indices in ascending order.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   i_in_valid / o_in_stall    i_in_data  (t_in_item)
//  result    o_out_valid / i_out_stall  o_out_data (t_out_item)
//  config    psel penable pwrite pready paddr pwdata prdata
//
//  A load writes its entry and its result together. A match scans n active
//  entries (one table read a cycle through the single RAM read port), then
//  lists the matching indices in ascending order, or one no-match result.
//  Synchronous active-low reset; match flags clear, the table is undefined.
//  Requests are stalled until the previous request has placed its last
//  result; a stalled result holds in the output register.
// ----------------------------------------------------------------------------
module ternary_classifier_match_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tcml_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tcml_pkg::t_out_item           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcml_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcml_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcml_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tcml_pkg::*;

    logic [POS_CNT_W-1:0] r_pos_count;
    logic [CNT_W-1:0]     r_cls_count;
    logic                 cfg_wr;
    logic                 reg_sel;
    t_dp_cmd              dp_cmd;
    t_dp_status           dp_status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_count <= POS_CNT_W'(MAX_POSITIONS);
            r_cls_count <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_POS_COUNT: r_pos_count <= pwdata[POS_CNT_W-1:0];
                REG_CLS_COUNT: r_cls_count <= pwdata[CNT_W-1:0];
                default: begin
                    r_pos_count <= r_pos_count;
                end
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        case (reg_sel)
            REG_POS_COUNT: prdata = PDATA_W'(r_pos_count);
            REG_CLS_COUNT: prdata = PDATA_W'(r_cls_count);
            default:       prdata = '0;
        endcase
    end

    tcml_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    tcml_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in_data   (i_in_data),
        .i_pos_count (r_pos_count),
        .i_cls_count (r_cls_count),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- verif/tb_ternary_classifier_match_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ternary_classifier_match_list
// Self-checking bench for the ternary match list. A directed table of loads,
// matches and register writes comes first. Random phases follow, each under
// its own position and entry counts. Every result is checked, field by field,
// against a behavioural model or hand-read answers. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_ternary_classifier_match_list;
    import tcml_pkg::*;

    localparam int GAP_MAX     = 14;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 49;
    localparam int DRAIN_WAIT  = 80;

    // Hand-read answer for a directed request, or none
    typedef struct packed {
        logic      typed;
        t_out_item answer;
    } t_glance;

    // One row of the directed table: a register write or a request
    typedef struct packed {
        logic               is_cfg;
        logic               reg_sel;
        logic [PDATA_W-1:0] wdata;
        t_in_item           req;
        logic               typed;
        t_out_item          answer;
    } t_plan_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Shadow of the condition table and its registers
    bit   [WORD_W-1:0]      tcam_care   [MAX_ENTRIES];
    bit   [WORD_W-1:0]      tcam_value  [MAX_ENTRIES];
    bit                     tcam_loaded [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hit_flags       = '0;
    logic [POS_CNT_W-1:0]   cfg_positions   = POS_CNT_W'(32);   // reset value
    logic [CNT_W-1:0]       cfg_classifiers = '0;

    t_out_item owed_results [$];
    t_glance   glance_q     [$];
    int        mismatches = 0;
    bit        tx_quiet   = 1'b0;
    bit        rx_quiet   = 1'b0;

    ternary_classifier_match_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic int active_entries();
        return (cfg_classifiers > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_classifiers);
    endfunction

    // Work out the results of one accepted request and queue them
    function automatic void classify(input t_in_item req);
        logic [WORD_W-1:0]      pmask;
        logic [MAX_ENTRIES-1:0] hits;
        int                     pc;
        int                     n;
        int                     total;
        int                     k;
        t_out_item              r;
        pc    = (cfg_positions > MAX_POSITIONS) ? MAX_POSITIONS : int'(cfg_positions);
        pmask = (pc >= WORD_W) ? '1 : (WORD_W'(1) << pc) - WORD_W'(1);
        r     = '0;
        if (req.command == CMD_LOAD) begin
            tcam_care[req.entry_index]   = req.care_bits;
            tcam_value[req.entry_index]  = req.value_bits;
            tcam_loaded[req.entry_index] = 1'b1;
            r.result_kind = KIND_LOAD;
            r.match_index = req.entry_index;
            r.specificity = SPEC_W'($countones(req.care_bits & pmask));
            r.last        = 1'b1;
            owed_results.push_back(r);
        end else begin
            n     = active_entries();
            hits  = '0;
            total = 0;
            for (int i = 0; i < n; i++) begin
                if (((tcam_value[i] ^ req.message_bits) & tcam_care[i] & pmask) == '0) begin
                    hits[i] = 1'b1;
                    total++;
                end
                hit_flags[i] = hits[i];
            end
            if (total == 0) begin
                r.result_kind = KIND_NONE;
                r.last        = 1'b1;
                owed_results.push_back(r);
            end else begin
                // list the hits in ascending order, marking the final one
                k = 0;
                for (int i = 0; i < n; i++) begin
                    if (hits[i]) begin
                        k++;
                        r.result_kind = KIND_MATCH;
                        r.match_index = ENTRY_AW'(i);
                        r.match_total = CNT_W'(total);
                        r.last        = (k == total);
                        owed_results.push_back(r);
                    end
                end
            end
        end
    endfunction

    // Follow register writes, model accepted requests, check accepted results
    always @(posedge i_clk) begin : watch
        t_glance   g;
        t_out_item want;
        if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_POS_COUNT) begin
                cfg_positions = pwdata[POS_CNT_W-1:0];
            end else begin
                cfg_classifiers = pwdata[CNT_W-1:0];
            end
        end
        if (i_in_valid && !o_in_stall) begin
            g = glance_q.pop_front();
            classify(i_in_data);
            // a hand-read answer stands in for the single modelled one
            if (g.typed) begin
                void'(owed_results.pop_back());
                owed_results.push_back(g.answer);
            end
        end
        if (o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing owed", o_out_data));
            end else begin
                want = owed_results.pop_front();
                if (o_out_data.result_kind !== want.result_kind)
                    report_mismatch($sformatf("result_kind %0d, want %0d",
                                              o_out_data.result_kind, want.result_kind));
                if (o_out_data.match_index !== want.match_index)
                    report_mismatch($sformatf("match_index %0d, want %0d",
                                              o_out_data.match_index, want.match_index));
                if (o_out_data.specificity !== want.specificity)
                    report_mismatch($sformatf("specificity %0d, want %0d",
                                              o_out_data.specificity, want.specificity));
                if (o_out_data.match_total !== want.match_total)
                    report_mismatch($sformatf("match_total %0d, want %0d",
                                              o_out_data.match_total, want.match_total));
                if (o_out_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              o_out_data.last, want.last));
            end
        end
    end

    // Stall the result side for a random number of cycles before each result
    initial begin
        int stall_len;
        forever begin
            stall_len = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) @(posedge i_clk);
        end
    end

    // Idle for a random gap, then hold the request until it is taken
    task automatic send_request(input t_in_item req, input logic typed,
                                input t_out_item answer);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        glance_q.push_back(t_glance'{typed, answer});
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic sel, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({sel, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (!wr) begin
            want = (sel == REG_POS_COUNT) ? PDATA_W'(cfg_positions) : PDATA_W'(cfg_classifiers);
            if (prdata !== want)
                report_mismatch($sformatf("register %0d reads %h, want %h", sel, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register once idle, with junk above the field, and read it back
    task automatic program_register(input logic sel, input int unsigned value);
        int unsigned width;
        width = (sel == REG_POS_COUNT) ? POS_CNT_W : CNT_W;
        settle();
        apb_access(1'b1, sel, PDATA_W'(value) | ($urandom << width));
        apb_access(1'b0, sel, '0);
    endtask

    function automatic t_in_item load_req(input int unsigned idx,
                                          input logic [WORD_W-1:0] care, value);
        t_in_item req;
        req.command      = CMD_LOAD;
        req.entry_index  = ENTRY_AW'(idx);
        req.care_bits    = care;
        req.value_bits   = value;
        req.message_bits = $urandom;
        return req;
    endfunction

    function automatic t_in_item match_req(input logic [WORD_W-1:0] msg);
        t_in_item req;
        req.command      = CMD_MATCH;
        req.entry_index  = ENTRY_AW'($urandom_range(0, MAX_ENTRIES - 1));
        req.care_bits    = $urandom;
        req.value_bits   = $urandom;
        req.message_bits = msg;
        return req;
    endfunction

    function automatic t_out_item load_done(input int unsigned idx, input int unsigned spec);
        t_out_item r;
        r             = '0;
        r.result_kind = KIND_LOAD;
        r.match_index = ENTRY_AW'(idx);
        r.specificity = SPEC_W'(spec);
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic t_out_item no_match();
        t_out_item r;
        r             = '0;
        r.result_kind = KIND_NONE;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic t_plan_row plan_req(input t_in_item req, input logic typed,
                                           input t_out_item answer);
        t_plan_row row;
        row        = '0;
        row.req    = req;
        row.typed  = typed;
        row.answer = answer;
        return row;
    endfunction

    function automatic t_plan_row plan_cfg(input logic sel, input int unsigned value);
        t_plan_row row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.wdata   = PDATA_W'(value);
        return row;
    endfunction

    // Draw a random request; fill any unloaded compared entry first
    function automatic t_in_item random_request();
        t_in_item req;
        int       n;
        int       hole;
        int       j;
        n    = active_entries();
        hole = -1;
        for (int i = n - 1; i >= 0; i--) begin
            if (!tcam_loaded[i]) hole = i;
        end
        req = match_req($urandom);
        if (hole >= 0 || $urandom_range(0, 99) < 40) begin
            req.command = CMD_LOAD;
            if (hole >= 0) begin
                req.entry_index = ENTRY_AW'(hole);
            end else if (n > 0 && $urandom_range(0, 1) == 1) begin
                req.entry_index = ENTRY_AW'($urandom_range(0, n - 1));
            end
            case ($urandom_range(0, 9))
                0:          req.care_bits = '0;
                1:          req.care_bits = '1;
                2, 3, 4, 5: req.care_bits = $urandom & $urandom & $urandom;
                default:    ;
            endcase
        end else begin
            // aim most messages at a stored entry so that lists get long
            j = (n > 0) ? $urandom_range(0, n - 1) : 0;
            case ($urandom_range(0, 7))
                0, 1, 2, 3: req.message_bits = tcam_value[j] ^ ($urandom & ~tcam_care[j]);
                4:          req.message_bits = tcam_value[j] ^ (WORD_W'(1) << $urandom_range(0, 31));
                5:          req.message_bits = ($urandom_range(0, 1) == 1) ? '1 : '0;
                default:    ;
            endcase
        end
        return req;
    endfunction

    initial begin
        t_plan_row plan [$];
        int        pos_plan [PHASES];
        int        cls_plan [PHASES];

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: reset counts first, then small tables and odd counts
        plan.push_back(plan_req(match_req('0), 1'b1, no_match()));
        plan.push_back(plan_req(match_req('1), 1'b1, no_match()));
        plan.push_back(plan_req(load_req(0, '1, '1), 1'b1, load_done(0, 32)));
        plan.push_back(plan_req(load_req(63, '0, '0), 1'b1, load_done(63, 0)));
        plan.push_back(plan_req(load_req(1, '0, '1), 1'b1, load_done(1, 0)));
        plan.push_back(plan_req(load_req(2, 32'h0000_ffff, 32'h0000_1234), 1'b1,
                                load_done(2, 16)));
        plan.push_back(plan_req(load_req(3, 32'h8000_0001, 32'h8000_0000), 1'b1,
                                load_done(3, 2)));
        plan.push_back(plan_req(load_req(4, 32'haaaa_aaaa, '0), 1'b1, load_done(4, 16)));
        plan.push_back(plan_cfg(REG_CLS_COUNT, 5));
        plan.push_back(plan_req(match_req('1), 1'b0, '0));
        plan.push_back(plan_req(match_req(32'h0000_1234), 1'b0, '0));
        plan.push_back(plan_req(match_req('0), 1'b0, '0));
        // no positions compared: every active entry matches
        plan.push_back(plan_cfg(REG_POS_COUNT, 0));
        plan.push_back(plan_req(match_req($urandom), 1'b0, '0));
        plan.push_back(plan_req(load_req(5, '1, $urandom), 1'b1, load_done(5, 0)));
        plan.push_back(plan_cfg(REG_POS_COUNT, 1));
        plan.push_back(plan_req(load_req(6, '1, '0), 1'b1, load_done(6, 1)));
        plan.push_back(plan_req(match_req(32'h0000_0001), 1'b0, '0));
        // oversized position count saturates to the word width
        plan.push_back(plan_cfg(REG_POS_COUNT, 63));
        plan.push_back(plan_req(load_req(7, '1, '0), 1'b1, load_done(7, 32)));
        plan.push_back(plan_req(match_req(32'h8000_0000), 1'b0, '0));
        plan.push_back(plan_cfg(REG_CLS_COUNT, 8));
        plan.push_back(plan_req(match_req('0), 1'b0, '0));
        plan.push_back(plan_req(load_req(63, '1, '1), 1'b1, load_done(63, 32)));
        plan.push_back(plan_req(match_req('1), 1'b0, '0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                program_register(plan[i].reg_sel, plan[i].wdata);
            end else begin
                send_request(plan[i].req, plan[i].typed, plan[i].answer);
            end
        end

        // Random phases, each under its own counts, extremes among them
        pos_plan = '{32, 4, 63, 0, 1, 8, 0, 32};
        cls_plan = '{127, 64, 64, 40, 0, 64, 0, 1};
        pos_plan[6] = $urandom_range(0, 63);
        cls_plan[6] = $urandom_range(0, 127);
        for (int ph = 0; ph < PHASES; ph++) begin
            program_register(REG_POS_COUNT, pos_plan[ph]);
            program_register(REG_CLS_COUNT, cls_plan[ph]);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
        end

        settle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
